FILE: sv/ecbp_pkg.sv
// Shared types and constants for the escape-coded bit packer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package ecbp_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int COUNT_WIDTH = 16;
   localparam int MAX_WIDTH   = 24;
   localparam int MAX_CHUNK   = 16;
   localparam int FIELD_W     = 5;
   localparam int BYTE_W      = 8;
   localparam int COUNT_OUT_W = 16;

   // signed datum after sign extension and offset, with headroom for the offset
   localparam int DATUM_W   = ((VALUE_WIDTH > MAX_WIDTH) ? VALUE_WIDTH : MAX_WIDTH) + 2;
   // longest bit segment: w ones plus the sign bit
   localparam int SEG_W     = MAX_WIDTH + 1;
   localparam int SEG_LEN_W = $clog2(SEG_W + 1);

   localparam logic OP_FLUSH = 1'b1;

   typedef struct packed {
      logic               flush;
      logic               escape;
      logic               sign;
      logic [FIELD_W-1:0] w;
      logic [FIELD_W-1:0] c;
      logic [DATUM_W-1:0] payload;
   } cmd_type;

   typedef struct packed {
      logic [BYTE_W-1:0]      byte_out;
      logic                   byte_valid;
      logic [COUNT_OUT_W-1:0] escape_count;
      logic                   last;
   } rsp_type;

endpackage

`default_nettype wire

FILE: sv/ecbp_front.sv
// Front end: takes input items, clamps widths, applies the signed offset and
// classifies each value as direct or escaped. Depends on ecbp_pkg.
`default_nettype none

module ecbp_front (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  push,
   output      logic                                  full,
   input  wire logic                                  op,
   input  wire logic signed [ecbp_pkg::VALUE_WIDTH-1:0] value,
   input  wire logic [ecbp_pkg::FIELD_W-1:0]          width,
   input  wire logic [ecbp_pkg::FIELD_W-1:0]          chunk_width,
   input  wire logic                                  is_signed,
   output      logic                                  cmd_valid,
   output      ecbp_pkg::cmd_type                     cmd,
   input  wire logic                                  cmd_ready
);

   logic                            accept;
   logic [ecbp_pkg::FIELD_W-1:0]    w_cl;
   logic [ecbp_pkg::FIELD_W-1:0]    c_cl;
   logic [ecbp_pkg::FIELD_W-1:0]    w_m1;
   logic [ecbp_pkg::DATUM_W-1:0]    ext;
   logic [ecbp_pkg::DATUM_W-1:0]    offset;
   logic [ecbp_pkg::DATUM_W-1:0]    lim;
   logic                            neg;
   logic                            direct;

   logic                            st_valid_ff, st_valid_in;
   logic                            st_flush_ff, st_flush_in;
   logic [ecbp_pkg::FIELD_W-1:0]    st_w_ff, st_w_in;
   logic [ecbp_pkg::FIELD_W-1:0]    st_c_ff, st_c_in;
   logic [ecbp_pkg::DATUM_W-1:0]    st_datum_ff, st_datum_in;

   assign full   = st_valid_ff & ~cmd_ready;
   assign accept = push & ~full;

   always_comb begin
      w_cl = width;
      if (width == '0) begin
         w_cl = ecbp_pkg::FIELD_W'(1);
      end else if (width > ecbp_pkg::FIELD_W'(ecbp_pkg::MAX_WIDTH)) begin
         w_cl = ecbp_pkg::FIELD_W'(ecbp_pkg::MAX_WIDTH);
      end
      c_cl = chunk_width;
      if (chunk_width == '0) begin
         c_cl = ecbp_pkg::FIELD_W'(1);
      end else if (chunk_width > ecbp_pkg::FIELD_W'(ecbp_pkg::MAX_CHUNK)) begin
         c_cl = ecbp_pkg::FIELD_W'(ecbp_pkg::MAX_CHUNK);
      end
      w_m1   = w_cl - ecbp_pkg::FIELD_W'(1);
      ext    = ecbp_pkg::DATUM_W'(value);
      offset = is_signed ? ((ecbp_pkg::DATUM_W'(1) << w_m1) - ecbp_pkg::DATUM_W'(1)) : '0;

      // hold the staged item while the command queue is full
      st_valid_in = accept | (st_valid_ff & ~cmd_ready);
      st_flush_in = st_flush_ff;
      st_w_in     = st_w_ff;
      st_c_in     = st_c_ff;
      st_datum_in = st_datum_ff;
      if (accept) begin
         st_flush_in = (op == ecbp_pkg::OP_FLUSH);
         st_w_in     = w_cl;
         st_c_in     = c_cl;
         st_datum_in = ext + offset;
      end
   end

   // classify the staged item
   always_comb begin
      lim    = (ecbp_pkg::DATUM_W'(1) << st_w_ff) - ecbp_pkg::DATUM_W'(1);
      neg    = st_datum_ff[ecbp_pkg::DATUM_W-1];
      direct = ~neg & (st_datum_ff < lim);

      cmd.flush   = st_flush_ff;
      cmd.escape  = ~direct;
      cmd.sign    = neg;
      cmd.w       = st_w_ff;
      cmd.c       = st_c_ff;
      if (direct) begin
         cmd.payload = st_datum_ff;
      end else if (neg) begin
         cmd.payload = ~st_datum_ff;
      end else begin
         cmd.payload = st_datum_ff - lim;
      end
   end

   assign cmd_valid = st_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff <= 1'b0;
      end else begin
         st_valid_ff <= st_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      st_flush_ff <= st_flush_in;
      st_w_ff     <= st_w_in;
      st_c_ff     <= st_c_in;
      st_datum_ff <= st_datum_in;
   end

endmodule

`default_nettype wire

FILE: sv/ecbp_cmd_queue.sv
// Two-entry command queue between the front end and the bit sequencer.
// Depends on ecbp_pkg for the command type.
`default_nettype none

module ecbp_cmd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_valid,
   input  wire ecbp_pkg::cmd_type wr_data,
   output      logic              wr_ready,
   output      logic              rd_valid,
   output      ecbp_pkg::cmd_type rd_data,
   input  wire logic              rd_pop
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   ecbp_pkg::cmd_type  entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_wr;
   logic               do_rd;

   assign wr_ready = (cnt_ff != CNT_W'(DEPTH));
   assign rd_valid = (cnt_ff != '0);
   assign rd_data  = entry_ff[rd_ptr_ff];
   assign do_wr    = wr_valid & wr_ready;
   assign do_rd    = rd_pop & rd_valid;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + CNT_W'(do_wr) - CNT_W'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

FILE: sv/ecbp_back.sv
// Bit sequencer: writes each command's bit segments into the byte register,
// up to one byte boundary per cycle, and holds the escape count.
// Depends on ecbp_pkg.
`default_nettype none

module ecbp_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  wire ecbp_pkg::cmd_type cmd,
   output      logic              cmd_pop,
   input  wire logic              rsp_full,
   output      logic              rsp_push,
   output      ecbp_pkg::rsp_type rsp_data
);

   typedef enum logic [1:0] {S_IDLE, S_SEG, S_FINISH} state_type;

   localparam int CM_W = ecbp_pkg::MAX_CHUNK + 1;

   state_type                           state_ff, state_in;
   logic [ecbp_pkg::BYTE_W-1:0]         part_ff, part_in;
   logic [2:0]                          cnt_ff, cnt_in;
   logic [ecbp_pkg::COUNT_WIDTH-1:0]    esc_ff, esc_in;
   logic [ecbp_pkg::SEG_W-1:0]          seg_ff, seg_in;
   logic [ecbp_pkg::SEG_LEN_W-1:0]      len_ff, len_in;
   logic [ecbp_pkg::DATUM_W-1:0]        mag_ff, mag_in;
   logic [ecbp_pkg::FIELD_W-1:0]        c_ff, c_in;
   logic                                more_ff, more_in;
   logic                                held_valid_ff, held_valid_in;
   logic [ecbp_pkg::BYTE_W-1:0]         held_byte_ff, held_byte_in;

   logic [3:0]                          room;
   logic [3:0]                          take;
   logic [3:0]                          total;
   logic [ecbp_pkg::BYTE_W-1:0]         bits8;
   logic [ecbp_pkg::BYTE_W-1:0]         merged;
   logic [ecbp_pkg::SEG_W-1:0]          seg_next;
   logic [ecbp_pkg::SEG_LEN_W-1:0]      len_next;
   logic [ecbp_pkg::DATUM_W-1:0]        mag_sh;
   logic                                cont;
   logic [ecbp_pkg::MAX_CHUNK-1:0]      cmask;
   logic [ecbp_pkg::SEG_W-1:0]          chunk_seg;
   logic [ecbp_pkg::SEG_W-1:0]          head_seg;

   always_comb begin
      room     = 4'd8 - {1'b0, cnt_ff};
      take     = (len_ff < ecbp_pkg::SEG_LEN_W'(room)) ? 4'(len_ff) : room;
      bits8    = seg_ff[ecbp_pkg::BYTE_W-1:0] & ecbp_pkg::BYTE_W'((9'd1 << take) - 9'd1);
      merged   = part_ff | (bits8 << cnt_ff);
      total    = {1'b0, cnt_ff} + take;
      seg_next = seg_ff >> take;
      len_next = len_ff - ecbp_pkg::SEG_LEN_W'(take);

      // next chunk: low c bits of the magnitude and a continue bit above them
      mag_sh    = mag_ff >> c_ff;
      cont      = |mag_sh;
      cmask     = ecbp_pkg::MAX_CHUNK'((CM_W'(1) << c_ff) - CM_W'(1));
      chunk_seg = ecbp_pkg::SEG_W'(mag_ff[ecbp_pkg::MAX_CHUNK-1:0] & cmask)
                | (ecbp_pkg::SEG_W'(cont) << c_ff);

      // escape head: w ones and the sign bit
      head_seg  = ((ecbp_pkg::SEG_W'(1) << cmd.w) - ecbp_pkg::SEG_W'(1))
                | (ecbp_pkg::SEG_W'(cmd.sign) << cmd.w);
   end

   always_comb begin
      state_in      = state_ff;
      part_in       = part_ff;
      cnt_in        = cnt_ff;
      esc_in        = esc_ff;
      seg_in        = seg_ff;
      len_in        = len_ff;
      mag_in        = mag_ff;
      c_in          = c_ff;
      more_in       = more_ff;
      held_valid_in = held_valid_ff;
      held_byte_in  = held_byte_ff;
      cmd_pop       = 1'b0;
      rsp_push      = 1'b0;
      rsp_data.byte_out     = held_byte_ff;
      rsp_data.byte_valid   = 1'b1;
      rsp_data.escape_count = '0;
      rsp_data.last         = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid && !rsp_full) begin
               cmd_pop = 1'b1;
               if (cmd.flush) begin
                  rsp_push              = 1'b1;
                  rsp_data.byte_out     = (cnt_ff != '0) ? part_ff : '0;
                  rsp_data.byte_valid   = (cnt_ff != '0);
                  rsp_data.escape_count = ecbp_pkg::COUNT_OUT_W'(esc_ff);
                  rsp_data.last         = 1'b1;
                  part_in = '0;
                  cnt_in  = '0;
                  esc_in  = '0;
               end else if (cmd.escape) begin
                  seg_in   = head_seg;
                  len_in   = ecbp_pkg::SEG_LEN_W'(cmd.w) + ecbp_pkg::SEG_LEN_W'(1);
                  mag_in   = cmd.payload;
                  c_in     = cmd.c;
                  more_in  = 1'b1;
                  state_in = S_SEG;
                  if (esc_ff != '1) begin
                     esc_in = esc_ff + ecbp_pkg::COUNT_WIDTH'(1);
                  end
               end else begin
                  seg_in   = ecbp_pkg::SEG_W'(cmd.payload[ecbp_pkg::MAX_WIDTH-1:0]);
                  len_in   = ecbp_pkg::SEG_LEN_W'(cmd.w);
                  more_in  = 1'b0;
                  state_in = S_SEG;
               end
            end
         end
         S_SEG: begin
            if (!rsp_full) begin
               if (total == 4'd8) begin
                  // release the previous byte, hold the new one until more follow
                  rsp_push      = held_valid_ff;
                  held_byte_in  = merged;
                  held_valid_in = 1'b1;
                  part_in       = '0;
                  cnt_in        = '0;
               end else begin
                  part_in = merged;
                  cnt_in  = total[2:0];
               end
               seg_in = seg_next;
               len_in = len_next;
               if (len_next == '0) begin
                  if (more_ff) begin
                     seg_in  = chunk_seg;
                     len_in  = ecbp_pkg::SEG_LEN_W'(c_ff) + ecbp_pkg::SEG_LEN_W'(1);
                     mag_in  = mag_sh;
                     more_in = cont;
                  end else begin
                     state_in = S_FINISH;
                  end
               end
            end
         end
         S_FINISH: begin
            if (!held_valid_ff) begin
               state_in = S_IDLE;
            end else if (!rsp_full) begin
               rsp_push      = 1'b1;
               rsp_data.last = 1'b1;
               held_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         part_ff       <= '0;
         cnt_ff        <= '0;
         esc_ff        <= '0;
         more_ff       <= 1'b0;
         held_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         part_ff       <= part_in;
         cnt_ff        <= cnt_in;
         esc_ff        <= esc_in;
         more_ff       <= more_in;
         held_valid_ff <= held_valid_in;
      end
      seg_ff       <= seg_in;
      len_ff       <= len_in;
      mag_ff       <= mag_in;
      c_ff         <= c_in;
      held_byte_ff <= held_byte_in;
   end

`ifndef SYNTHESIS
   a_part_clean: assert property (@(posedge clock) disable iff (reset)
      (part_ff >> cnt_ff) == '0)
      else $error("partial byte has bits above the fill position");

   a_held_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !held_valid_ff)
      else $error("held byte left over after an item ended");

   a_seg_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEG) |-> (len_ff != '0))
      else $error("segment state with no bits left");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result written into a full queue");

   a_esc_flush: assert property (@(posedge clock) disable iff (reset)
      (cmd_pop && cmd.flush) |=> (esc_ff == '0) && (cnt_ff == '0))
      else $error("flush did not clear count and partial byte");
`endif

endmodule

`default_nettype wire

FILE: sv/ecbp_rsp_queue.sv
// Four-entry result queue that presents results on the output side.
// Depends on ecbp_pkg for the result type.
`default_nettype none

module ecbp_rsp_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_push,
   input  wire ecbp_pkg::rsp_type wr_data,
   output      logic              wr_full,
   output      logic              rd_empty,
   output      ecbp_pkg::rsp_type rd_data,
   input  wire logic              rd_pop
);

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   ecbp_pkg::rsp_type  entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_wr;
   logic               do_rd;

   assign wr_full  = (cnt_ff == CNT_W'(DEPTH));
   assign rd_empty = (cnt_ff == '0);
   assign rd_data  = entry_ff[rd_ptr_ff];
   assign do_wr    = wr_push & ~wr_full;
   assign do_rd    = rd_pop & ~rd_empty;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + CNT_W'(do_wr) - CNT_W'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

FILE: sv/escape_coded_bit_packer_unit.sv
// Escape-coded bit packer. Items are pushed through a one-stage front end that
// clamps the widths, adds the signed offset and classifies the value, into a
// two-entry command queue; the front end takes one item per cycle until that
// queue fills. The bit sequencer behind it starts an item in its idle state,
// takes one step for each byte boundary or segment end it reaches (a segment
// is the direct value, the escape head of w ones plus sign, or one chunk with
// its continue bit, at most 8 bits written per cycle), and closes the item in
// its finish state; a flush is handled in the idle state. Results wait in a
// four-entry queue, and the sequencer stalls only while that queue is full.
// Depends on ecbp_pkg, ecbp_front, ecbp_cmd_queue, ecbp_back, ecbp_rsp_queue.
`default_nettype none

module escape_coded_bit_packer_unit (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    push,
   output      logic                                    full,
   input  wire logic                                    req_op,
   input  wire logic signed [ecbp_pkg::VALUE_WIDTH-1:0] req_value,
   input  wire logic [ecbp_pkg::FIELD_W-1:0]            req_width,
   input  wire logic [ecbp_pkg::FIELD_W-1:0]            req_chunk_width,
   input  wire logic                                    req_is_signed,
   output      logic                                    empty,
   input  wire logic                                    pop,
   output      logic [ecbp_pkg::BYTE_W-1:0]             rsp_byte_out,
   output      logic                                    rsp_byte_valid,
   output      logic [ecbp_pkg::COUNT_OUT_W-1:0]        rsp_escape_count,
   output      logic                                    rsp_last
);

   logic              fe_valid;
   ecbp_pkg::cmd_type fe_cmd;
   logic              cq_ready;
   logic              cq_valid;
   ecbp_pkg::cmd_type cq_cmd;
   logic              cq_pop;
   logic              rq_full;
   logic              rq_push;
   ecbp_pkg::rsp_type rq_wr_data;
   ecbp_pkg::rsp_type rq_head;

   ecbp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .op          (req_op),
      .value       (req_value),
      .width       (req_width),
      .chunk_width (req_chunk_width),
      .is_signed   (req_is_signed),
      .cmd_valid   (fe_valid),
      .cmd         (fe_cmd),
      .cmd_ready   (cq_ready)
   );

   ecbp_cmd_queue u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fe_valid),
      .wr_data  (fe_cmd),
      .wr_ready (cq_ready),
      .rd_valid (cq_valid),
      .rd_data  (cq_cmd),
      .rd_pop   (cq_pop)
   );

   ecbp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cq_valid),
      .cmd       (cq_cmd),
      .cmd_pop   (cq_pop),
      .rsp_full  (rq_full),
      .rsp_push  (rq_push),
      .rsp_data  (rq_wr_data)
   );

   ecbp_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_push  (rq_push),
      .wr_data  (rq_wr_data),
      .wr_full  (rq_full),
      .rd_empty (empty),
      .rd_data  (rq_head),
      .rd_pop   (pop)
   );

   assign rsp_byte_out     = rq_head.byte_out;
   assign rsp_byte_valid   = rq_head.byte_valid;
   assign rsp_escape_count = rq_head.escape_count;
   assign rsp_last         = rq_head.last;

endmodule

`default_nettype wire

FILE: bench/tb.sv
// Testbench for escape_coded_bit_packer_unit: directed and random value/flush traffic
// with random stalls on both queues, checked against a bit-level packing predictor.
// Depends on ecbp_pkg and the unit itself.

module tb;

   localparam logic OP_ENCODE = 1'b0;
   localparam int   N_RANDOM  = 280;

   typedef struct packed {
      logic                                    op;
      logic signed [ecbp_pkg::VALUE_WIDTH-1:0] value;
      logic [ecbp_pkg::FIELD_W-1:0]            width;
      logic [ecbp_pkg::FIELD_W-1:0]            chunk;
      logic                                    is_signed;
   } sample_type;

   class packer_scoreboard;
      ecbp_pkg::rsp_type           bytes_due[$];
      ecbp_pkg::rsp_type           fresh[$];
      logic [ecbp_pkg::BYTE_W-1:0] acc_byte;
      int unsigned                 acc_bits;
      longint unsigned             escape_total;
      int                          mismatches;

      function new();
         acc_byte = '0;
         acc_bits = 0;
         escape_total = 0;
         mismatches = 0;
      endfunction

      // Shift n bits into the partial byte, LSB first; emit each completed byte.
      function void shift_in_bits(longint unsigned bits, int unsigned n);
         ecbp_pkg::rsp_type r;
         for (int unsigned i = 0; i < n; i++) begin
            acc_byte[acc_bits] = bits[i];
            acc_bits++;
            if (acc_bits == ecbp_pkg::BYTE_W) begin
               r.byte_out = acc_byte;
               r.byte_valid = 1'b1;
               r.escape_count = '0;
               r.last = 1'b0;
               fresh.push_back(r);
               acc_byte = '0;
               acc_bits = 0;
            end
         end
      endfunction

      function void note_item(sample_type s);
         int unsigned       w, c;
         longint            datum, lim;
         longint unsigned   mag, cmask;
         ecbp_pkg::rsp_type r;
         if (s.op == ecbp_pkg::OP_FLUSH) begin
            r.byte_out = (acc_bits != 0) ? acc_byte : '0;
            r.byte_valid = (acc_bits != 0);
            r.escape_count = escape_total[ecbp_pkg::COUNT_OUT_W-1:0];
            r.last = 1'b1;
            bytes_due.push_back(r);
            acc_byte = '0;
            acc_bits = 0;
            escape_total = 0;
            return;
         end
         w = s.width;
         if (w == 0) w = 1;
         if (w > ecbp_pkg::MAX_WIDTH) w = ecbp_pkg::MAX_WIDTH;
         c = s.chunk;
         if (c == 0) c = 1;
         if (c > ecbp_pkg::MAX_CHUNK) c = ecbp_pkg::MAX_CHUNK;
         datum = longint'($signed(s.value));
         if (s.is_signed) datum += (longint'(1) << (w - 1)) - 1;
         lim = (longint'(1) << w) - 1;
         fresh.delete();
         if (datum >= 0 && datum < lim) begin
            shift_in_bits(datum, w);
         end else begin
            if (escape_total < (longint'(1) << ecbp_pkg::COUNT_WIDTH) - 1) escape_total++;
            shift_in_bits(lim, w);
            if (datum < 0) begin
               mag = -(datum + 1);
               shift_in_bits(1, 1);
            end else begin
               mag = datum - lim;
               shift_in_bits(0, 1);
            end
            cmask = (longint'(1) << c) - 1;
            while (mag > cmask) begin
               shift_in_bits(mag & cmask, c);
               mag >>= c;
               shift_in_bits(1, 1);
            end
            shift_in_bits(mag, c);
            shift_in_bits(0, 1);
         end
         if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
         foreach (fresh[i]) bytes_due.push_back(fresh[i]);
      endfunction

      function void check_byte(ecbp_pkg::rsp_type got);
         ecbp_pkg::rsp_type want;
         if (bytes_due.size() == 0) begin
            $display("%0t: expected no result, actual byte_out=%h byte_valid=%b %s%h last=%b",
                     $time, got.byte_out, got.byte_valid, "escape_count=", got.escape_count,
                     got.last);
            mismatches++;
            return;
         end
         want = bytes_due.pop_front();
         if (got.byte_out !== want.byte_out) begin
            $display("%0t: byte_out expected %h actual %h", $time, want.byte_out, got.byte_out);
            mismatches++;
         end
         if (got.byte_valid !== want.byte_valid) begin
            $display("%0t: byte_valid expected %b actual %b", $time, want.byte_valid,
                     got.byte_valid);
            mismatches++;
         end
         if (got.escape_count !== want.escape_count) begin
            $display("%0t: escape_count expected %h actual %h", $time, want.escape_count,
                     got.escape_count);
            mismatches++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, got.last);
            mismatches++;
         end
      endfunction
   endclass

   logic                                    clock;
   logic                                    reset;
   logic                                    push;
   logic                                    full;
   logic                                    req_op;
   logic signed [ecbp_pkg::VALUE_WIDTH-1:0] req_value;
   logic [ecbp_pkg::FIELD_W-1:0]            req_width;
   logic [ecbp_pkg::FIELD_W-1:0]            req_chunk_width;
   logic                                    req_is_signed;
   logic                                    empty;
   logic                                    pop;
   logic [ecbp_pkg::BYTE_W-1:0]             rsp_byte_out;
   logic                                    rsp_byte_valid;
   logic [ecbp_pkg::COUNT_OUT_W-1:0]        rsp_escape_count;
   logic                                    rsp_last;

   packer_scoreboard  sb = new();
   ecbp_pkg::rsp_type got_byte;
   bit                tx_jitter;
   bit                rx_jitter;
   int                hold_req;
   int                hold_left;
   int                gap_left;

   escape_coded_bit_packer_unit dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_op           (req_op),
      .req_value        (req_value),
      .req_width        (req_width),
      .req_chunk_width  (req_chunk_width),
      .req_is_signed    (req_is_signed),
      .empty            (empty),
      .pop              (pop),
      .rsp_byte_out     (rsp_byte_out),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_escape_count (rsp_escape_count),
      .rsp_last         (rsp_last)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic sample_type item_of(logic op,
                                          logic signed [ecbp_pkg::VALUE_WIDTH-1:0] value,
                                          int w, int c, logic sg);
      sample_type s;
      s.op = op;
      s.value = value;
      s.width = w[ecbp_pkg::FIELD_W-1:0];
      s.chunk = c[ecbp_pkg::FIELD_W-1:0];
      s.is_signed = sg;
      return s;
   endfunction

   // Mostly in-range values, some around both escape boundaries, some anything.
   function automatic sample_type pick_item();
      sample_type s;
      int         w, kind;
      longint     lim, off, v;
      s.op = ($urandom_range(0, 9) == 0) ? ecbp_pkg::OP_FLUSH : OP_ENCODE;
      if ($urandom_range(0, 9) == 0)
         s.width = $urandom_range(0, 1) ? 5'd0 :
                   5'($urandom_range(ecbp_pkg::MAX_WIDTH + 1, 31));
      else
         s.width = 5'($urandom_range(1, ecbp_pkg::MAX_WIDTH));
      if ($urandom_range(0, 9) == 0)
         s.chunk = $urandom_range(0, 1) ? 5'd0 :
                   5'($urandom_range(ecbp_pkg::MAX_CHUNK + 1, 31));
      else
         s.chunk = 5'($urandom_range(1, ecbp_pkg::MAX_CHUNK));
      s.is_signed = 1'($urandom_range(0, 1));
      w = (s.width == 0) ? 1 :
          ((s.width > ecbp_pkg::MAX_WIDTH) ? ecbp_pkg::MAX_WIDTH : s.width);
      lim = (longint'(1) << w) - 1;
      off = s.is_signed ? (longint'(1) << (w - 1)) - 1 : 0;
      kind = $urandom_range(0, 9);
      if (kind <= 5)
         v = longint'($urandom_range(0, 32'(lim - 1))) - off;
      else if (kind <= 7)
         v = lim - off + longint'($urandom_range(0, 40)) - 20;
      else if (kind == 8)
         v = -off + 3 - longint'($urandom_range(0, 30));
      else
         v = longint'($signed($urandom()));
      s.value = v[ecbp_pkg::VALUE_WIDTH-1:0];
      return s;
   endfunction

   // Offer one item; it transfers at the first rising edge with full low.
   task automatic push_item(input sample_type s);
      if (tx_jitter && $urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            @(negedge clock);
            push <= 1'b0;
         end
      end
      @(negedge clock);
      push <= 1'b1;
      req_op <= s.op;
      req_value <= s.value;
      req_width <= s.width;
      req_chunk_width <= s.chunk;
      req_is_signed <= s.is_signed;
      do @(posedge clock); while (full);
      sb.note_item(s);
   endtask

   task automatic await_drain();
      @(negedge clock);
      push <= 1'b0;
      while (sb.bytes_due.size() != 0) @(posedge clock);
   endtask

   // Receiver: random short stalls, plus one long hold-off on request.
   initial begin
      pop = 1'b0;
      hold_left = 0;
      gap_left = 0;
      forever begin
         @(negedge clock);
         if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
         end
         if (hold_left != 0) begin
            pop <= 1'b0;
            hold_left--;
         end else if (gap_left != 0) begin
            pop <= 1'b0;
            gap_left--;
         end else if (rx_jitter && $urandom_range(0, 4) == 0) begin
            pop <= 1'b0;
            gap_left = $urandom_range(0, 2);
         end else begin
            pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         got_byte.byte_out = rsp_byte_out;
         got_byte.byte_valid = rsp_byte_valid;
         got_byte.escape_count = rsp_escape_count;
         got_byte.last = rsp_last;
         sb.check_byte(got_byte);
      end
   end

   initial begin
      #30000000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      reset = 1'b1;
      push = 1'b0;
      req_op = OP_ENCODE;
      req_value = '0;
      req_width = '0;
      req_chunk_width = '0;
      req_is_signed = 1'b0;
      tx_jitter = 1'b1;
      rx_jitter = 1'b1;
      hold_req = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      push_item(item_of(ecbp_pkg::OP_FLUSH, 0, 1, 1, 1'b0));  // nothing pending
      push_item(item_of(OP_ENCODE, 0, 1, 1, 1'b0));
      push_item(item_of(OP_ENCODE, 1, 1, 1, 1'b0));           // smallest escape
      push_item(item_of(OP_ENCODE, 32'h00fffffe, 24, 16, 1'b0));
      push_item(item_of(OP_ENCODE, 32'h00ffffff, 24, 16, 1'b0));
      push_item(item_of(ecbp_pkg::OP_FLUSH, 0, 1, 1, 1'b0));  // bits pending
      push_item(item_of(OP_ENCODE, 32'h7fffffff, 24, 1, 1'b0)); // longest chunk chain
      push_item(item_of(OP_ENCODE, 32'h80000000, 1, 1, 1'b1));
      push_item(item_of(OP_ENCODE, -1, 8, 4, 1'b0));           // negative escape
      push_item(item_of(OP_ENCODE, -127, 8, 3, 1'b1));
      push_item(item_of(OP_ENCODE, 128, 8, 3, 1'b1));
      push_item(item_of(OP_ENCODE, -128, 8, 3, 1'b1));
      push_item(item_of(OP_ENCODE, 127, 8, 3, 1'b1));
      push_item(item_of(OP_ENCODE, 5, 0, 0, 1'b0));            // widths clamp up
      push_item(item_of(OP_ENCODE, 32'h12345678, 31, 31, 1'b1)); // widths clamp down
      push_item(item_of(OP_ENCODE, 32'h7fffffff, 1, 16, 1'b0));
      push_item(item_of(OP_ENCODE, 3, 5, 17, 1'b1));
      push_item(item_of(OP_ENCODE, 32'h5a5a5a5a, 16, 0, 1'b1));
      push_item(item_of(ecbp_pkg::OP_FLUSH, 0, 1, 1, 1'b0));
      push_item(item_of(ecbp_pkg::OP_FLUSH, 0, 1, 1, 1'b0));

      for (int n = 0; n < N_RANDOM; n++) begin
         // hold the receiver off while items keep coming, to back up both queues
         if (n == 100) begin
            hold_req = 90;
            tx_jitter = 1'b0;
         end
         if (n == 125) tx_jitter = 1'b1;
         if (n == 200) await_drain();
         // no stalls on either side from here on
         if (n == 250) begin
            tx_jitter = 1'b0;
            rx_jitter = 1'b0;
         end
         push_item(pick_item());
      end

      push_item(item_of(ecbp_pkg::OP_FLUSH, 0, 1, 1, 1'b0));
      push_item(item_of(OP_ENCODE, 2, 1, 1, 1'b0));
      push_item(item_of(ecbp_pkg::OP_FLUSH, 0, 1, 1, 1'b0));

      await_drain();
      repeat (40) @(posedge clock);
      if (sb.mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
